>>> sv/goldbach_prime_pair_finder_unit_defines.svh
// assertion helpers shared by the rtl files
`ifndef GOLDBACH_PRIME_PAIR_FINDER_UNIT_DEFINES_SVH
`define GOLDBACH_PRIME_PAIR_FINDER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// property that must hold at every clock edge outside reset
`define GPF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("gpf assertion failed");
// implication checked in the same cycle
`define GPF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gpf assertion failed");
`else
`define GPF_ASSERT(lbl, prop)
`define GPF_ASSERT_IMP(lbl, ante, cons)
`endif

`endif

>>> sv/gpf_pkg.sv
package gpf_pkg;

  localparam int unsigned WIDTH = 16;
  // running square of the trial divisor overshoots the candidate by a little
  localparam int unsigned SQ_W  = WIDTH + 2;
  localparam int unsigned CNT_W = $clog2(WIDTH + 1);

  localparam logic OP_PRIME = 1'b0;
  localparam logic OP_PAIR  = 1'b1;

  typedef struct packed {
    logic             operation;
    logic [WIDTH-1:0] number;
  } gpf_in_t;

  typedef struct packed {
    logic             number_prime;
    logic             pair_found;
    logic [WIDTH-1:0] smaller_prime;
    logic [WIDTH-1:0] larger_prime;
  } gpf_out_t;

  typedef struct packed {
    logic             start;
    logic [WIDTH-1:0] dividend;
    logic [WIDTH-1:0] divisor;
  } gpf_div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic rem_zero;
  } gpf_div_rsp_t;

endpackage

>>> sv/gpf_rem_unit.sv
`include "goldbach_prime_pair_finder_unit_defines.svh"

module gpf_rem_unit
  import gpf_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  gpf_div_req_t req_i,
  output gpf_div_rsp_t rsp_o
);

  logic [WIDTH-1:0] dvd_q, dvd_d;
  logic [WIDTH-1:0] dsr_q, dsr_d;
  logic [WIDTH-1:0] rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [WIDTH:0]   trial;

  // restoring remainder, one dividend bit a cycle
  assign trial = {rem_q, dvd_q[WIDTH-1]};

  always_comb begin
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      dvd_d = req_i.dividend;
      dsr_d = req_i.divisor;
      rem_d = '0;
      cnt_d = CNT_W'(WIDTH);
    end else if (cnt_q != '0) begin
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = WIDTH'(trial - {1'b0, dsr_q});
      end else begin
        rem_d = trial[WIDTH-1:0];
      end
      dvd_d  = {dvd_q[WIDTH-2:0], 1'b0};
      cnt_d  = cnt_q - CNT_W'(1);
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign rsp_o.busy     = (cnt_q != '0);
  assign rsp_o.done     = done_q;
  assign rsp_o.rem_zero = (rem_q == '0);

  `GPF_ASSERT_IMP(a_done_after_busy, done_q, $past(cnt_q) == CNT_W'(1))
  `GPF_ASSERT_IMP(a_no_start_busy, req_i.start, cnt_q == '0)
  `GPF_ASSERT(a_done_not_busy, !(done_q && (cnt_q != '0)))

endmodule

>>> sv/goldbach_prime_pair_finder_unit.sv
// channel   direction  ports                 transfer
// command   in         start_i, item_i       start_i high while busy_o low
// result    out        done_o, result_o      done_o high for one cycle, never held off
//
// one trial division by the shared remainder unit runs a start, WIDTH shift steps and
// a verdict; a primality test of n runs about sqrt(n)/2 of them, and operation 0
// answers n < 3 and even n without any trial division
// operation 1 runs a test of p and, when p is prime, one of n - p, for each p from 2
// until a pair is found or p passes n/2; for n below 4 no pair is reported from idle
// reset clears the sequencer and the strobe; busy_o stays high until done_o pulses
// the result register frees the sequencer, so a new start may arrive with done_o

`include "goldbach_prime_pair_finder_unit_defines.svh"

module goldbach_prime_pair_finder_unit
  import gpf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  gpf_in_t  item_i,
  output logic     busy_o,
  output logic     done_o,
  output gpf_out_t result_o
);

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,  // waiting for a command
    S_TEST = 4'b0010,  // trivial cases of the candidate
    S_LOOP = 4'b0100,  // divisor square against candidate
    S_WAIT = 4'b1000   // remainder unit at work
  } state_e;

  state_e           state_q, state_d;
  logic             op_q, op_d;
  logic [WIDTH-1:0] num_q, num_d;
  logic [WIDTH-1:0] p_q, p_d;
  logic [WIDTH-1:0] cand_q, cand_d;
  logic             phase_q, phase_d;   // low while testing p, high while testing n - p
  logic [WIDTH-1:0] d_q, d_d;           // odd trial divisor
  logic [SQ_W-1:0]  sq_q, sq_d;         // square of the trial divisor
  gpf_out_t         res_q, res_d;
  logic             done_q, done_d;

  logic             verdict_vld;
  logic             verdict;
  logic [WIDTH-1:0] half;
  logic [WIDTH-1:0] p_inc;

  gpf_div_req_t     div_req;
  gpf_div_rsp_t     div_rsp;

  assign half  = num_q >> 1;
  assign p_inc = p_q + WIDTH'(1);

  gpf_rem_unit u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    num_d    = num_q;
    p_d      = p_q;
    cand_d   = cand_q;
    phase_d  = phase_q;
    d_d      = d_q;
    sq_d     = sq_q;
    res_d    = res_q;
    done_d   = 1'b0;
    verdict_vld      = 1'b0;
    verdict          = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = cand_q;
    div_req.divisor  = d_q;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d    = item_i.operation;
          num_d   = item_i.number;
          phase_d = 1'b0;
          p_d     = WIDTH'(2);
          if (item_i.operation == OP_PRIME) begin
            cand_d  = item_i.number;
            state_d = S_TEST;
          end else if ((item_i.number >> 1) < WIDTH'(2)) begin
            // no pair below four
            res_d  = '0;
            done_d = 1'b1;
          end else begin
            cand_d  = WIDTH'(2);
            state_d = S_TEST;
          end
        end
      end
      S_TEST: begin
        if (cand_q < WIDTH'(2)) begin
          verdict_vld = 1'b1;
          verdict     = 1'b0;
        end else if (cand_q == WIDTH'(2)) begin
          verdict_vld = 1'b1;
          verdict     = 1'b1;
        end else if (!cand_q[0]) begin
          verdict_vld = 1'b1;
          verdict     = 1'b0;
        end else begin
          d_d     = WIDTH'(3);
          sq_d    = SQ_W'(9);
          state_d = S_LOOP;
        end
      end
      S_LOOP: begin
        if (sq_q > SQ_W'(cand_q)) begin
          verdict_vld = 1'b1;
          verdict     = 1'b1;
        end else begin
          div_req.start = 1'b1;
          state_d       = S_WAIT;
        end
      end
      S_WAIT: begin
        if (div_rsp.done) begin
          if (div_rsp.rem_zero) begin
            verdict_vld = 1'b1;
            verdict     = 1'b0;
          end else begin
            // (d + 2)^2 = d^2 + 4d + 4
            d_d     = d_q + WIDTH'(2);
            sq_d    = sq_q + SQ_W'({d_q, 2'b00}) + SQ_W'(4);
            state_d = S_LOOP;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // act on the outcome of one primality test
    if (verdict_vld) begin
      if (op_q == OP_PRIME) begin
        res_d              = '0;
        res_d.number_prime = verdict;
        done_d             = 1'b1;
        state_d            = S_IDLE;
      end else if (!phase_q && verdict) begin
        phase_d = 1'b1;
        cand_d  = num_q - p_q;
        state_d = S_TEST;
      end else if (phase_q && verdict) begin
        res_d               = '0;
        res_d.pair_found    = 1'b1;
        res_d.smaller_prime = p_q;
        res_d.larger_prime  = num_q - p_q;
        done_d              = 1'b1;
        state_d             = S_IDLE;
      end else if (p_inc > half) begin
        // scan exhausted
        res_d   = '0;
        done_d  = 1'b1;
        state_d = S_IDLE;
      end else begin
        p_d     = p_inc;
        cand_d  = p_inc;
        phase_d = 1'b0;
        state_d = S_TEST;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    num_q   <= num_d;
    p_q     <= p_d;
    cand_q  <= cand_d;
    phase_q <= phase_d;
    d_q     <= d_d;
    sq_q    <= sq_d;
    res_q   <= res_d;
  end

  assign busy_o   = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

  `GPF_ASSERT_IMP(a_pair_sums, done_q && res_q.pair_found,
                  (res_q.smaller_prime + res_q.larger_prime) == num_q)
  `GPF_ASSERT(a_one_kind, !(done_q && res_q.number_prime && res_q.pair_found))
  `GPF_ASSERT_IMP(a_odd_divisor, state_q == S_WAIT, d_q[0] && div_rsp.busy || div_rsp.done)
  `GPF_ASSERT_IMP(a_idle_after_done, done_q, state_q == S_IDLE || $past(start_i))

endmodule

>>> tb/gpf_goldbach_checker.sv
module gpf_goldbach_checker
  import gpf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  gpf_in_t     item_i,
  input  logic        busy_i,
  input  logic        done_i,
  input  gpf_out_t    result_i,
  output int unsigned failures_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  gpf_out_t    answers_q[$];
  int unsigned mismatch_count = 0;
  int unsigned answers_waiting = 0;

  assign failures_o = mismatch_count;
  assign pending_o  = answers_waiting;

  function automatic logic trial_division_prime(logic [WIDTH-1:0] value);
    int unsigned n;
    int unsigned d;
    n = value;
    if (n < 2) return 1'b0;
    if (n == 2) return 1'b1;
    if (n % 2 == 0) return 1'b0;
    for (d = 3; d * d <= n; d += 2) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // primality verdict, or the smallest goldbach split p + (n - p)
  function automatic gpf_out_t goldbach_answer(gpf_in_t cmd);
    gpf_out_t    ans;
    int unsigned n;
    int unsigned p;
    ans = '0;
    n   = cmd.number;
    if (cmd.operation == OP_PRIME) begin
      ans.number_prime = trial_division_prime(cmd.number);
      return ans;
    end
    for (p = 2; p <= n / 2 && !ans.pair_found; p++) begin
      if (trial_division_prime(WIDTH'(p)) && trial_division_prime(WIDTH'(n - p))) begin
        ans.pair_found    = 1'b1;
        ans.smaller_prime = WIDTH'(p);
        ans.larger_prime  = WIDTH'(n - p);
      end
    end
    return ans;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // results are retired before a command taken on the same edge is queued
  always @(posedge clk_i) begin
    gpf_out_t want;
    if (rst_ni) begin
      if (done_i) begin
        if (answers_q.size() == 0) begin
          report_mismatch($sformatf("result %h with nothing outstanding", result_i));
        end else begin
          want = answers_q.pop_front();
          if (result_i.number_prime !== want.number_prime)
            report_mismatch($sformatf("number_prime expected %0d got %0d",
                                      want.number_prime, result_i.number_prime));
          if (result_i.pair_found !== want.pair_found)
            report_mismatch($sformatf("pair_found expected %0d got %0d",
                                      want.pair_found, result_i.pair_found));
          if (result_i.smaller_prime !== want.smaller_prime)
            report_mismatch($sformatf("smaller_prime expected %0d got %0d",
                                      want.smaller_prime, result_i.smaller_prime));
          if (result_i.larger_prime !== want.larger_prime)
            report_mismatch($sformatf("larger_prime expected %0d got %0d",
                                      want.larger_prime, result_i.larger_prime));
        end
      end
      if (start_i && !busy_i) begin
        answers_q.push_back(goldbach_answer(item_i));
      end
      answers_waiting = answers_q.size();
    end
  end

endmodule

>>> tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gpf_pkg::*;

  // command channel towards the finder, result channel back from it
  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  gpf_in_t     item_i;
  logic        busy_o;
  logic        done_o;
  gpf_out_t    result_o;

  int unsigned failures;
  int unsigned pending_answers;
  logic        burst;

  // directed commands: field extremes, both operations, the small-number corners,
  // squares of odd primes (divisor bound), odd numbers with no split, and a large
  // odd number whose split is 2 plus the largest 16-bit prime
  localparam int unsigned N_DIRECTED = 24;
  localparam logic [WIDTH:0] DIRECTED [N_DIRECTED] = '{
    {OP_PRIME, WIDTH'(0)},     {OP_PRIME, WIDTH'(1)},     {OP_PRIME, WIDTH'(2)},
    {OP_PRIME, WIDTH'(3)},     {OP_PRIME, WIDTH'(4)},     {OP_PRIME, WIDTH'(9)},
    {OP_PRIME, WIDTH'(25)},    {OP_PRIME, WIDTH'(49)},    {OP_PRIME, WIDTH'(32768)},
    {OP_PRIME, WIDTH'(65519)}, {OP_PRIME, WIDTH'(65521)}, {OP_PRIME, WIDTH'(65535)},
    {OP_PAIR,  WIDTH'(0)},     {OP_PAIR,  WIDTH'(1)},     {OP_PAIR,  WIDTH'(3)},
    {OP_PAIR,  WIDTH'(4)},     {OP_PAIR,  WIDTH'(5)},     {OP_PAIR,  WIDTH'(7)},
    {OP_PAIR,  WIDTH'(11)},    {OP_PAIR,  WIDTH'(27)},    {OP_PAIR,  WIDTH'(100)},
    {OP_PAIR,  WIDTH'(65523)}, {OP_PAIR,  WIDTH'(65532)}, {OP_PAIR,  WIDTH'(65534)}
  };

  goldbach_prime_pair_finder_unit dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .item_i   (item_i),
    .busy_o   (busy_o),
    .done_o   (done_o),
    .result_o (result_o)
  );

  gpf_goldbach_checker checker_i (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .item_i     (item_i),
    .busy_i     (busy_o),
    .done_i     (done_o),
    .result_i   (result_o),
    .failures_o (failures),
    .pending_o  (pending_answers)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // called on the edge that completed the previous transfer (or ended reset);
  // a zero gap keeps start_i high so back-to-back commands get one assignment a step
  task automatic issue_command(gpf_in_t cmd);
    int unsigned gap;
    gap = burst ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    item_i  <= cmd;
    // the transfer happens on the first edge that sees busy_o low
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  initial begin
    gpf_in_t     cmd;
    int unsigned sel;
    rst_ni  = 1'b0;
    start_i = 1'b0;
    item_i  = '0;
    burst   = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part, with random gaps
    for (int i = 0; i < N_DIRECTED; i++) begin
      issue_command(gpf_in_t'(DIRECTED[i]));
    end

    // random part; long pair searches only come from large even numbers,
    // odd pair searches stay small since an odd number without a split scans to n/2
    for (int i = 0; i < 76; i++) begin
      // every so often switch to a stretch of back-to-back commands
      if (i % 16 == 0) burst = ($urandom_range(0, 3) == 0);
      sel = $urandom_range(0, 9);
      if ($urandom_range(0, 1) == 0) begin
        cmd.operation = OP_PRIME;
        if (sel < 4)      cmd.number = WIDTH'($urandom);
        else if (sel < 7) cmd.number = WIDTH'($urandom) | WIDTH'(1);
        else              cmd.number = WIDTH'($urandom_range(0, 64));
      end else begin
        cmd.operation = OP_PAIR;
        if (sel < 6)      cmd.number = WIDTH'($urandom_range(4, 65534)) & ~WIDTH'(1);
        else if (sel < 9) cmd.number = WIDTH'($urandom_range(0, 255) * 2 + 1);
        else              cmd.number = WIDTH'($urandom_range(0, 15));
      end
      issue_command(cmd);
    end
    start_i <= 1'b0;

    // drain outstanding answers, sampled away from the active edge
    while (pending_answers != 0) @(negedge clk_i);
    // nothing more may come out; allow a short settle to catch stray strobes
    repeat (40) @(negedge clk_i);

    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run of this stimulus
  initial begin
    #2_000_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

>>> goldbach_prime_pair_finder_unit.f
+incdir+sv
sv/gpf_pkg.sv
sv/gpf_rem_unit.sv
sv/goldbach_prime_pair_finder_unit.sv
tb/gpf_goldbach_checker.sv
tb/tb.sv
